// ----- src/tse_pkg.sv -----
// Shared types and codes for the table search engine.
package tse_pkg;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 16;
  localparam int POS_W   = 7;
  localparam int HELD_W  = 7;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LINEAR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SENTINEL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BINARY   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIB      = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } tse_in_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic              status;
    logic [HELD_W-1:0] entries_held;
  } tse_out_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic set_full;
    logic app_start;
    logic ins_step;
    logic lin_start;
    logic lin_step;
    logic bin_init;
    logic bin_probe;
    logic bin_cmp;
    logic fib_init;
    logic fib_grow;
    logic fib_probe;
    logic fib_cmp;
    logic tail_rd;
    logic tail_cmp;
    logic out_load;
  } tse_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              cnt_zero;
    logic              ins_shift;
    logic              lin_hit;
    logic              lin_last;
    logic              bin_active;
    logic              key_eq;
    logic              fib_more;
    logic              fib_loop;
    logic              tail_ok;
    logic              out_free;
  } tse_sts_t;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DECODE    = 11'b000_0000_0010,
    ST_INS       = 11'b000_0000_0100,
    ST_LIN       = 11'b000_0000_1000,
    ST_BIN_PROBE = 11'b000_0001_0000,
    ST_BIN_CMP   = 11'b000_0010_0000,
    ST_FIB_GROW  = 11'b000_0100_0000,
    ST_FIB_PROBE = 11'b000_1000_0000,
    ST_FIB_CMP   = 11'b001_0000_0000,
    ST_FIB_TAIL  = 11'b010_0000_0000,
    ST_RESP      = 11'b100_0000_0000
  } tse_state_t;

endpackage

// ----- src/tse_ctrl.sv -----
// Controller state machine sequencing clear, append and the four searches.
module tse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tse_pkg::tse_sts_t sts,
  output tse_pkg::tse_cmd_t cmd
);

  tse_pkg::tse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tse_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != tse_pkg::ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      tse_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tse_pkg::ST_DECODE;
        end
      end
      tse_pkg::ST_DECODE: begin
        state_nxt = tse_pkg::ST_RESP;
        case (sts.mode)
          tse_pkg::MODE_CLEAR: cmd.clear = 1'b1;
          tse_pkg::MODE_APPEND: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.app_start = 1'b1;
              state_nxt     = tse_pkg::ST_INS;
            end
          end
          tse_pkg::MODE_LINEAR, tse_pkg::MODE_SENTINEL: begin
            if (!sts.cnt_zero) begin
              cmd.lin_start = 1'b1;
              state_nxt     = tse_pkg::ST_LIN;
            end
          end
          tse_pkg::MODE_BINARY: begin
            cmd.bin_init = 1'b1;
            state_nxt    = tse_pkg::ST_BIN_PROBE;
          end
          tse_pkg::MODE_FIB: begin
            cmd.fib_init = 1'b1;
            state_nxt    = tse_pkg::ST_FIB_GROW;
          end
          default: state_nxt = tse_pkg::ST_RESP;
        endcase
      end
      tse_pkg::ST_INS: begin
        cmd.ins_step = 1'b1;
        if (!sts.ins_shift) begin
          state_nxt = tse_pkg::ST_RESP;
        end
      end
      tse_pkg::ST_LIN: begin
        cmd.lin_step = 1'b1;
        if (sts.lin_hit || sts.lin_last) begin
          state_nxt = tse_pkg::ST_RESP;
        end
      end
      tse_pkg::ST_BIN_PROBE: begin
        if (sts.bin_active) begin
          cmd.bin_probe = 1'b1;
          state_nxt     = tse_pkg::ST_BIN_CMP;
        end else begin
          state_nxt = tse_pkg::ST_RESP;
        end
      end
      tse_pkg::ST_BIN_CMP: begin
        cmd.bin_cmp = 1'b1;
        state_nxt   = sts.key_eq ? tse_pkg::ST_RESP : tse_pkg::ST_BIN_PROBE;
      end
      tse_pkg::ST_FIB_GROW: begin
        if (sts.fib_more) begin
          cmd.fib_grow = 1'b1;
        end else begin
          state_nxt = tse_pkg::ST_FIB_PROBE;
        end
      end
      tse_pkg::ST_FIB_PROBE: begin
        if (sts.fib_loop) begin
          cmd.fib_probe = 1'b1;
          state_nxt     = tse_pkg::ST_FIB_CMP;
        end else if (sts.tail_ok) begin
          cmd.tail_rd = 1'b1;
          state_nxt   = tse_pkg::ST_FIB_TAIL;
        end else begin
          state_nxt = tse_pkg::ST_RESP;
        end
      end
      tse_pkg::ST_FIB_CMP: begin
        cmd.fib_cmp = 1'b1;
        state_nxt   = sts.key_eq ? tse_pkg::ST_RESP : tse_pkg::ST_FIB_PROBE;
      end
      tse_pkg::ST_FIB_TAIL: begin
        cmd.tail_cmp = 1'b1;
        state_nxt    = tse_pkg::ST_RESP;
      end
      tse_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tse_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/tse_dpath.sv -----
// Datapath: key memories, count, search index registers and result register.
module tse_dpath #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tse_pkg::tse_in_t  in_data,
  input  tse_pkg::tse_cmd_t cmd,
  output tse_pkg::tse_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output tse_pkg::tse_out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = AW + 3;
  localparam logic signed [FW-1:0] ONE_S = FW'(1);
  localparam logic signed [FW-1:0] ZERO_S = '0;

  logic [KEY_WIDTH-1:0] arrival_mem [DEPTH];
  logic [KEY_WIDTH-1:0] sorted_mem  [DEPTH];

  logic [tse_pkg::MODE_W-1:0] mode_r;
  logic [KEY_WIDTH-1:0]       key_r;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              j_r;
  logic [AW-1:0]              idx_r;
  logic [CW-1:0]              lo_r, hx_r, mid_r;
  logic signed [FW-1:0]       f_r, f1_r, f2_r, base_r, fi_r;
  logic [KEY_WIDTH-1:0]       ard_r, srd_r;
  logic                       hit_r, full_r;
  logic [CW-1:0]              pos_r;
  logic                       out_valid_r;
  tse_pkg::tse_out_t          out_data_r;

  logic [AW-1:0]        ard_addr, srd_addr;
  logic                 swr_en;
  logic [KEY_WIDTH-1:0] swr_data;
  logic [CW:0]          msum;
  logic [CW-1:0]        mid_c;
  logic signed [FW-1:0] n_s, nm1_s, fsum, fi_c, fdiff;
  logic                 out_free;

  assign n_s   = $signed(FW'(cnt_r));
  assign nm1_s = n_s - ONE_S;
  assign msum  = {1'b0, lo_r} + {1'b0, hx_r} - (CW + 1)'(1);
  assign mid_c = msum[CW:1];
  assign fsum  = base_r + f2_r;
  assign fdiff = f1_r - f2_r;

  always_comb begin
    fi_c = (fsum > nm1_s) ? nm1_s : fsum;
    if (fi_c < ZERO_S) begin
      fi_c = ZERO_S;
    end
  end

  always_comb begin
    if (cmd.app_start) begin
      srd_addr = AW'(cnt_r - CW'(1));
    end else if (cmd.bin_probe) begin
      srd_addr = AW'(mid_c);
    end else if (cmd.fib_probe) begin
      srd_addr = AW'(fi_c);
    end else if (cmd.tail_rd) begin
      srd_addr = AW'(base_r + ONE_S);
    end else begin
      srd_addr = AW'(j_r - CW'(2));
    end
  end

  assign ard_addr = cmd.lin_step ? AW'(idx_r + AW'(1)) : '0;
  assign swr_en   = cmd.ins_step;
  assign swr_data = sts.ins_shift ? srd_r : key_r;

  always_ff @(posedge clk) begin
    if (cmd.app_start) begin
      arrival_mem[AW'(cnt_r)] <= key_r;
    end
    ard_r <= arrival_mem[ard_addr];
  end

  always_ff @(posedge clk) begin
    if (swr_en) begin
      sorted_mem[AW'(j_r)] <= swr_data;
    end
    srd_r <= sorted_mem[srd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
    end else if (cmd.ins_step && !sts.ins_shift) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      key_r  <= KEY_WIDTH'(in_data.value);
      hit_r  <= 1'b0;
      full_r <= 1'b0;
      pos_r  <= '0;
    end
    if (cmd.set_full) begin
      full_r <= 1'b1;
    end
    if (cmd.app_start) begin
      j_r <= cnt_r;
    end
    if (cmd.ins_step && sts.ins_shift) begin
      j_r <= j_r - CW'(1);
    end
    if (cmd.lin_start) begin
      idx_r <= '0;
    end
    if (cmd.lin_step) begin
      if (sts.lin_hit) begin
        hit_r <= 1'b1;
        pos_r <= CW'(idx_r) + CW'(1);
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
    if (cmd.bin_init) begin
      lo_r <= '0;
      hx_r <= cnt_r;
    end
    if (cmd.bin_probe) begin
      mid_r <= mid_c;
    end
    if (cmd.bin_cmp) begin
      if (sts.key_eq) begin
        hit_r <= 1'b1;
        pos_r <= mid_r + CW'(1);
      end else if (srd_r < key_r) begin
        lo_r <= mid_r + CW'(1);
      end else begin
        hx_r <= mid_r;
      end
    end
    if (cmd.fib_init) begin
      f2_r   <= ZERO_S;
      f1_r   <= ONE_S;
      f_r    <= ONE_S;
      base_r <= -ONE_S;
    end
    if (cmd.fib_grow) begin
      f2_r <= f1_r;
      f1_r <= f_r;
      f_r  <= f1_r + f_r;
    end
    if (cmd.fib_probe) begin
      fi_r <= fi_c;
    end
    if (cmd.fib_cmp) begin
      if (sts.key_eq) begin
        hit_r <= 1'b1;
        pos_r <= CW'(fi_r + ONE_S);
      end else if (srd_r < key_r) begin
        f_r    <= f1_r;
        f1_r   <= f2_r;
        f2_r   <= fdiff;
        base_r <= fi_r;
      end else begin
        f_r  <= f2_r;
        f1_r <= fdiff;
        f2_r <= f2_r - fdiff;
      end
    end
    if (cmd.tail_cmp && sts.key_eq) begin
      hit_r <= 1'b1;
      pos_r <= CW'(base_r + ONE_S + ONE_S);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.found        <= hit_r;
      out_data_r.position     <= tse_pkg::POS_W'(pos_r);
      out_data_r.status       <= full_r;
      out_data_r.entries_held <= tse_pkg::HELD_W'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.mode       = mode_r;
  assign sts.full       = (cnt_r == CW'(DEPTH));
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.ins_shift  = (j_r != '0) && (srd_r > key_r);
  assign sts.lin_hit    = (ard_r == key_r);
  assign sts.lin_last   = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign sts.bin_active = (lo_r < hx_r);
  assign sts.key_eq     = (srd_r == key_r);
  assign sts.fib_more   = (f_r < n_s);
  assign sts.fib_loop   = (f_r > ONE_S);
  assign sts.tail_ok    = (f1_r != ZERO_S) && ((base_r + ONE_S) < n_s);
  assign sts.out_free   = out_free;

endmodule

// ----- src/table_search_engine_unit.sv -----
// Top level of the table search engine: controller plus datapath.
//
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------
//  input   | in_valid, in_stall, in_data    | mode, value
//  result  | out_valid, out_stall, out_data | found, position, status, entries_held
//
// One transaction in flight; a new one is taken while the previous result waits.
// Append shifts each larger key up one slot before writing it; linear/sentinel scan arrival order;
// binary alternates probe and compare states; Fibonacci grows its numbers, then alternates probe
// and compare, with an optional tail check. One read port per memory sets the pace.
// Synchronous active-low reset empties the table; key storage is not cleared.
// A stalled result holds in the output register; the block waits only to load the next.
module table_search_engine_unit #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tse_pkg::tse_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tse_pkg::tse_out_t out_data
);

  tse_pkg::tse_cmd_t cmd;
  tse_pkg::tse_sts_t sts;

  tse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tse_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/table_search_engine_unit_test.sv -----
// Self-checking testbench for the table search engine: predicts each result and compares.
module table_search_engine_unit_test;

  localparam int DEPTH = 64;
  localparam int LIMIT = 600000;
  localparam int ITEMS = 1600;
  localparam logic [tse_pkg::MODE_W-1:0] MODE_NOP_A = 3'd6;
  localparam logic [tse_pkg::MODE_W-1:0] MODE_NOP_B = 3'd7;

  class search_scoreboard #(int SLOTS = 64);
    logic [tse_pkg::VALUE_W-1:0] arrival[SLOTS];
    logic [tse_pkg::VALUE_W-1:0] sorted[SLOTS];
    int held;
    tse_pkg::tse_out_t awaited[$];
    int mismatches;

    function int pending();
      return awaited.size();
    endfunction

    function void record_request(tse_pkg::tse_in_t req);
      logic [tse_pkg::VALUE_W-1:0] key;
      tse_pkg::tse_out_t res;
      int hit, lo, hi, mid, j, n, f, f1, f2, base, idx;
      key = req.value;
      hit = -1;
      res = '0;
      n = held;
      case (req.mode)
        tse_pkg::MODE_CLEAR: held = 0;
        tse_pkg::MODE_APPEND: begin
          if (held >= SLOTS) begin
            res.status = 1'b1;
          end else begin
            arrival[held] = key;
            j = held;
            while (j > 0 && sorted[j-1] > key) begin
              sorted[j] = sorted[j-1];
              j--;
            end
            sorted[j] = key;
            held++;
          end
        end
        tse_pkg::MODE_LINEAR, tse_pkg::MODE_SENTINEL: begin
          for (j = 0; j < n && hit < 0; j++)
            if (arrival[j] == key) hit = j;
        end
        tse_pkg::MODE_BINARY: begin
          lo = 0;
          hi = n - 1;
          while (lo <= hi && hit < 0) begin
            mid = (lo + hi) / 2;
            if (sorted[mid] == key) hit = mid;
            else if (sorted[mid] < key) lo = mid + 1;
            else hi = mid - 1;
          end
        end
        tse_pkg::MODE_FIB: begin
          f2 = 0;
          f1 = 1;
          f = 1;
          base = -1;
          while (f < n) begin
            f2 = f1;
            f1 = f;
            f = f2 + f1;
          end
          while (f > 1 && hit < 0) begin
            idx = base + f2;
            if (idx > n - 1) idx = n - 1;
            if (idx < 0) idx = 0;
            if (sorted[idx] < key) begin
              f = f1;
              f1 = f2;
              f2 = f - f1;
              base = idx;
            end else if (sorted[idx] > key) begin
              f = f2;
              f1 = f1 - f2;
              f2 = f - f1;
            end else begin
              hit = idx;
            end
          end
          if (hit < 0 && f1 != 0 && base + 1 < n && sorted[base+1] == key) hit = base + 1;
        end
        default: ;
      endcase
      res.found = (hit >= 0);
      res.position = (hit >= 0) ? tse_pkg::POS_W'(hit + 1) : '0;
      res.entries_held = tse_pkg::HELD_W'(held);
      awaited.push_back(res);
    endfunction

    function void check_reply(tse_pkg::tse_out_t got);
      tse_pkg::tse_out_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction found=%0b position=%0d status=%0b held=%0d",
                 $time, got.found, got.position, got.status, got.entries_held);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: expected found=%0b position=%0d status=%0b held=%0d",
                 $time, want.found, want.position, want.status, want.entries_held);
        $display("%0t:   actual found=%0b position=%0d status=%0b held=%0d",
                 $time, got.found, got.position, got.status, got.entries_held);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tse_pkg::tse_in_t in_data;
  logic out_valid;
  logic out_stall;
  tse_pkg::tse_out_t out_data;

  search_scoreboard #(DEPTH) book;
  bit tx_idle;
  bit rx_idle;
  bit long_hold;
  int sent;
  int unsigned cycles;

  table_search_engine_unit #(.DEPTH(DEPTH), .KEY_WIDTH(tse_pkg::VALUE_W)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) book.check_reply(out_data);
      if (in_valid === 1'b1 && in_stall === 1'b0) book.record_request(in_data);
    end
  end

  function automatic tse_pkg::tse_in_t make_item(logic [tse_pkg::MODE_W-1:0] m,
                                                 logic [tse_pkg::VALUE_W-1:0] v);
    tse_pkg::tse_in_t it;
    it.mode = m;
    it.value = v;
    return it;
  endfunction

  task automatic send_item(input tse_pkg::tse_in_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic run_episode(input int fill);
    logic [tse_pkg::VALUE_W-1:0] keys[$];
    logic [tse_pkg::VALUE_W-1:0] v;
    logic [tse_pkg::MODE_W-1:0] m;
    bit narrow;
    int r;
    narrow = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) != 0)
      send_item(make_item(tse_pkg::MODE_CLEAR, tse_pkg::VALUE_W'($urandom)));
    repeat (fill) begin
      v = narrow ? tse_pkg::VALUE_W'($urandom_range(0, 7)) : tse_pkg::VALUE_W'($urandom);
      if (keys.size() < DEPTH) keys.push_back(v);
      send_item(make_item(tse_pkg::MODE_APPEND, v));
    end
    repeat ($urandom_range(4, 16)) begin
      r = $urandom_range(0, 99);
      m = tse_pkg::MODE_W'($urandom_range(tse_pkg::MODE_LINEAR, tse_pkg::MODE_FIB));
      if (keys.size() != 0 && r < 55) v = keys[$urandom_range(0, keys.size() - 1)];
      else if (keys.size() != 0 && r < 75) v = keys[$urandom_range(0, keys.size() - 1)] + 1'b1;
      else v = narrow ? tse_pkg::VALUE_W'($urandom_range(0, 7)) : tse_pkg::VALUE_W'($urandom);
      if (r >= 97) m = tse_pkg::MODE_APPEND;
      else if (r >= 92) m = r[0] ? MODE_NOP_A : MODE_NOP_B;
      send_item(make_item(m, v));
    end
  endtask

  initial begin : receiver
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        hold = 150;
        long_hold = 1'b0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 4) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  initial begin : stimulus
    int ep, r, fill;
    book = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, unused modes, duplicates and key extremes
    send_item(make_item(tse_pkg::MODE_CLEAR, 16'hFFFF));
    send_item(make_item(tse_pkg::MODE_LINEAR, 16'h0000));
    send_item(make_item(tse_pkg::MODE_SENTINEL, 16'h0000));
    send_item(make_item(tse_pkg::MODE_BINARY, 16'h0000));
    send_item(make_item(tse_pkg::MODE_FIB, 16'h0000));
    send_item(make_item(MODE_NOP_A, 16'hAAAA));
    send_item(make_item(MODE_NOP_B, 16'h5555));
    send_item(make_item(tse_pkg::MODE_APPEND, 16'hFFFF));
    send_item(make_item(tse_pkg::MODE_FIB, 16'hFFFF));
    send_item(make_item(tse_pkg::MODE_APPEND, 16'h0000));
    send_item(make_item(tse_pkg::MODE_APPEND, 16'h8000));
    send_item(make_item(tse_pkg::MODE_APPEND, 16'h0000));
    send_item(make_item(tse_pkg::MODE_APPEND, 16'h7FFF));
    send_item(make_item(tse_pkg::MODE_LINEAR, 16'h0000));
    send_item(make_item(tse_pkg::MODE_SENTINEL, 16'hFFFF));
    send_item(make_item(tse_pkg::MODE_BINARY, 16'h8000));
    send_item(make_item(tse_pkg::MODE_FIB, 16'h7FFF));
    send_item(make_item(tse_pkg::MODE_FIB, 16'h0000));
    send_item(make_item(tse_pkg::MODE_BINARY, 16'h1234));
    send_item(make_item(tse_pkg::MODE_LINEAR, 16'h1234));
    send_item(make_item(tse_pkg::MODE_SENTINEL, 16'h4321));
    send_item(make_item(tse_pkg::MODE_FIB, 16'hFFFF));
    send_item(make_item(tse_pkg::MODE_CLEAR, 16'h0000));
    send_item(make_item(tse_pkg::MODE_BINARY, 16'hFFFF));

    ep = 0;
    while (sent < ITEMS) begin
      r = $urandom_range(0, 9);
      if (ep == 1) fill = DEPTH + 3;
      else if (r < 6) fill = $urandom_range(0, 12);
      else if (r < 9) fill = $urandom_range(13, DEPTH - 1);
      else fill = $urandom_range(DEPTH, DEPTH + 6);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (ep == 4) long_hold = 1'b1;
      if (ep == 8) drain();
      run_episode(fill);
      ep++;
    end

    drain();
    repeat (DEPTH + 16) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
